/* design/message_rate_limiter_core_defines.svh */
// assertion macros for the message rate limiter core
// expects i_clk and i_rst_n in the scope of each use
`ifndef MESSAGE_RATE_LIMITER_CORE_DEFINES_SVH
`define MESSAGE_RATE_LIMITER_CORE_DEFINES_SVH

// consequent checked in the same cycle
`define MRL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rate limiter check failed");

// consequent checked in the cycle after the antecedent
`define MRL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rate limiter check failed");

`endif

/* design/mrl_pkg.sv */
// shared types and constants of the message rate limiter
// no dependencies
`timescale 1ns / 1ps

package mrl_pkg;

    typedef enum logic [1:0] {
        VERDICT_OK       = 2'd0,
        VERDICT_FLOODING = 2'd1,
        VERDICT_KICK     = 2'd2
    } t_verdict;

    typedef enum logic {
        REG_LIMIT_PER_WINDOW = 1'b0,
        REG_KICK_THRESHOLD   = 1'b1
    } t_reg_idx;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned Q_W      = 16;
    localparam int unsigned ELAPSED_W = 4;

    localparam logic [Q_W-1:0]       ONE_MESSAGE     = 16'd256;
    localparam logic [ELAPSED_W-1:0] MAX_ELAPSED     = 4'd8;
    localparam logic [Q_W-1:0]       ALLOWANCE_RESET = 16'd1280;
    localparam logic [Q_W-1:0]       LIMIT_RESET     = 16'd2048;
    localparam logic [Q_W-1:0]       KICK_RESET      = 16'd50;

endpackage

/* design/mrl_req_if.sv */
// request channel of the message rate limiter: valid, ready, timestamp
// depends on mrl_pkg
`timescale 1ns / 1ps

interface mrl_req_if;
    logic                        valid;
    logic                        ready;
    logic [mrl_pkg::TIME_W-1:0]  now_seconds;

    modport source (output valid, output now_seconds, input ready);
    modport sink   (input valid, input now_seconds, output ready);
endinterface

/* design/mrl_rsp_if.sv */
// response channel of the message rate limiter: valid, ready, verdict
// depends on mrl_pkg
`timescale 1ns / 1ps

interface mrl_rsp_if;
    logic               valid;
    logic               ready;
    mrl_pkg::t_verdict  verdict;

    modport source (output valid, output verdict, input ready);
    modport sink   (input valid, input verdict, output ready);
endinterface

/* design/message_rate_limiter_core.sv */
// token-bucket message rate limiter, single module
// depends on mrl_pkg, mrl_req_if, mrl_rsp_if and the assertion macro header
//
// usage:
// - i_req carries one request per timestamp (now_seconds, whole seconds)
// - o_rsp returns one verdict per request, in order: ok, flooding or kick
// - i_cfg_we / i_cfg_idx / i_cfg_data write limit_per_window (index 0) and
//   kick_threshold (index 1); write only while no request is in flight
// - a taken request passes the input register, then the result register,
//   before its verdict shows on o_rsp
// - throughput: one request per cycle while o_rsp is ready; the bucket update (elapsed
//   clamp, 4x16 multiply, add, cap, spend) is combinational on the state registers
// - a stalled receiver holds the verdict in the result register; one more
//   request waits in the input register, then i_req.ready drops
// - synchronous reset: last time 0, allowance 5.0, overrun 0, limit 8.0,
//   kick threshold 50, both pipeline registers empty
`timescale 1ns / 1ps
`include "message_rate_limiter_core_defines.svh"

module message_rate_limiter_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  mrl_pkg::t_reg_idx          i_cfg_idx,
    input  logic [mrl_pkg::Q_W-1:0]    i_cfg_data,
    mrl_req_if.sink                    i_req,
    mrl_rsp_if.source                  o_rsp
);
    import mrl_pkg::*;

    logic                  r_in_valid;
    logic [TIME_W-1:0]     r_now;
    logic                  r_out_valid;
    t_verdict              r_verdict;

    logic [TIME_W-1:0]     r_last;
    logic [Q_W-1:0]        r_allowance;
    logic [Q_W-1:0]        r_overrun;
    logic [Q_W-1:0]        r_limit;
    logic [Q_W-1:0]        r_kick;

    logic [Q_W-1:0]        n_allowance;
    logic [Q_W-1:0]        n_overrun;
    t_verdict              n_verdict;

    logic                  fire;
    logic [TIME_W-1:0]     elapsed;
    logic [ELAPSED_W-1:0]  elapsed_clamped;
    logic [Q_W+ELAPSED_W-1:0] product;
    logic [Q_W:0]          gain;
    logic [Q_W+1:0]        level_raw;
    logic [Q_W-1:0]        level;
    logic [Q_W-1:0]        overrun_inc;

    // request in the input register moves on when the result slot is free
    assign fire        = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || fire;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.verdict = r_verdict;

    // elapsed time wraps; anything beyond eight seconds fills the bucket anyway
    assign elapsed         = r_now - r_last;
    assign elapsed_clamped = (elapsed > TIME_W'(MAX_ELAPSED)) ? MAX_ELAPSED
                                                              : elapsed[ELAPSED_W-1:0];
    assign product   = (Q_W+ELAPSED_W)'(elapsed_clamped) * (Q_W+ELAPSED_W)'(r_limit);
    assign gain      = product[Q_W+ELAPSED_W-1:3];
    assign level_raw = (Q_W+2)'(r_allowance) + (Q_W+2)'(gain);
    assign level     = (level_raw > (Q_W+2)'(r_limit)) ? r_limit : level_raw[Q_W-1:0];
    assign overrun_inc = (r_overrun == {Q_W{1'b1}}) ? r_overrun : r_overrun + Q_W'(1);

    always_comb begin
        n_allowance = r_allowance;
        n_overrun   = r_overrun;
        n_verdict   = VERDICT_OK;
        if (r_limit != '0) begin
            if (level < ONE_MESSAGE) begin
                n_overrun   = overrun_inc;
                n_allowance = level;
                n_verdict   = (overrun_inc > r_kick) ? VERDICT_KICK : VERDICT_FLOODING;
            end else begin
                n_overrun   = '0;
                n_allowance = level - ONE_MESSAGE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_last      <= '0;
            r_allowance <= ALLOWANCE_RESET;
            r_overrun   <= '0;
            r_limit     <= LIMIT_RESET;
            r_kick      <= KICK_RESET;
        end else begin
            if (i_req.valid && i_req.ready) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end

            if (fire) begin
                r_out_valid <= 1'b1;
                r_last      <= r_now;
                r_allowance <= n_allowance;
                r_overrun   <= n_overrun;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_LIMIT_PER_WINDOW: r_limit <= i_cfg_data;
                    REG_KICK_THRESHOLD:   r_kick  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_now <= i_req.now_seconds;
        end
        if (fire) begin
            r_verdict <= n_verdict;
        end
    end

    `MRL_ASSERT_NEXT(a_fire_gives_result, fire, r_out_valid)
    `MRL_ASSERT_NEXT(a_disabled_keeps_bucket, fire && (r_limit == '0),
        $stable(r_allowance) && $stable(r_overrun))
    `MRL_ASSERT_NEXT(a_bucket_capped, fire && (r_limit != '0),
        r_allowance <= $past(r_limit))
    `MRL_ASSERT_NEXT(a_reject_means_empty, fire && (n_verdict != VERDICT_OK),
        (r_allowance < ONE_MESSAGE) && (r_overrun != '0))

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// testbench of message_rate_limiter_core: each verdict is checked against a token-bucket
// predictor kept in a scoreboard class, with random idling on both handshake channels
// depends on mrl_pkg, mrl_req_if, mrl_rsp_if and the core

module testbench;
    import mrl_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 800000;
    localparam int unsigned CHUNKS        = 12;
    localparam int unsigned CHUNK_ITEMS   = 67;
    localparam int unsigned BURST_ITEMS   = 40;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned SETTLE_CYCLES = 8;

    class verdict_scoreboard;
        logic [Q_W-1:0]    limit;
        logic [Q_W-1:0]    threshold;
        logic [Q_W-1:0]    allowance;
        logic [Q_W-1:0]    overrun;
        logic [TIME_W-1:0] last_time;
        t_verdict          expected_q[$];
        int                errors;

        function new();
            limit     = LIMIT_RESET;
            threshold = KICK_RESET;
            allowance = ALLOWANCE_RESET;
            overrun   = '0;
            last_time = '0;
            errors    = 0;
        endfunction

        function void set_reg(t_reg_idx idx, logic [Q_W-1:0] value);
            if (idx == REG_LIMIT_PER_WINDOW) begin
                limit = value;
            end else begin
                threshold = value;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // bucket update for one request, verdict queued for the response side
        function void note_request(logic [TIME_W-1:0] now);
            logic [TIME_W-1:0] elapsed;
            logic [31:0]       level;
            t_verdict          verdict;
            elapsed   = now - last_time;
            last_time = now;
            if (limit == '0) begin
                expected_q.push_back(VERDICT_OK);
                return;
            end
            if (elapsed > MAX_ELAPSED) begin
                elapsed = TIME_W'(MAX_ELAPSED);
            end
            level = allowance + ((elapsed * limit) >> 3);
            if (level > limit) begin
                level = 32'(limit);
            end
            if (level < ONE_MESSAGE) begin
                if (overrun != '1) begin
                    overrun = overrun + Q_W'(1);
                end
                verdict = (overrun > threshold) ? VERDICT_KICK : VERDICT_FLOODING;
            end else begin
                overrun = '0;
                level   = level - ONE_MESSAGE;
                verdict = VERDICT_OK;
            end
            allowance = level[Q_W-1:0];
            expected_q.push_back(verdict);
        endfunction

        function void check_verdict(t_verdict got);
            t_verdict want;
            if (expected_q.size() == 0) begin
                $error("verdict: expected none, actual %0d", got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got !== want) begin
                $error("verdict: expected %0d, actual %0d", want, got);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    t_reg_idx          i_cfg_idx;
    logic [Q_W-1:0]    i_cfg_data;

    mrl_req_if req_if();
    mrl_rsp_if rsp_if();

    verdict_scoreboard board;
    int unsigned       sender_idle_pct   = 0;
    int unsigned       receiver_idle_pct = 0;
    bit                long_hold_req     = 1'b0;
    int unsigned       cycle_count       = 0;

    message_rate_limiter_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic pause_requests(input int unsigned cycles);
        req_if.valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic send_request(input logic [TIME_W-1:0] stamp);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct) gap++;
        if (gap != 0) begin
            pause_requests(gap);
        end
        req_if.valid       <= 1'b1;
        req_if.now_seconds <= stamp;
        do @(posedge i_clk); while (!req_if.ready);
        board.note_request(stamp);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [Q_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        board.set_reg(idx, value);
        @(posedge i_clk);
    endtask

    // no new request goes out while draining
    task automatic wait_for_verdicts();
        req_if.valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    // response side: takes verdicts, stalls at random or for one long stretch
    initial begin : verdict_sink
        int unsigned hold_left;
        hold_left = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
                board.check_verdict(rsp_if.verdict);
            end
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= ($urandom_range(99) >= receiver_idle_pct);
            end
        end
    end

    initial begin : request_source
        logic [TIME_W-1:0] stamp;
        logic [Q_W-1:0]    new_limit;
        logic [Q_W-1:0]    new_threshold;
        int unsigned       roll;
        board = new();
        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_idx          <= REG_LIMIT_PER_WINDOW;
        i_cfg_data         <= '0;
        req_if.valid       <= 1'b0;
        req_if.now_seconds <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset bucket holds five messages, then floods
        repeat (7) send_request(32'd0);
        send_request(32'd1);
        // backwards step and wrap both count as a long gap
        send_request(32'd0);
        send_request(32'hFFFF_FFFF);
        send_request(32'd7);
        wait_for_verdicts();

        // limiting off: always ok, bucket untouched
        write_reg(REG_LIMIT_PER_WINDOW, 16'd0);
        send_request(32'd5);
        send_request(32'd100);
        send_request(32'h8000_0000);
        wait_for_verdicts();

        // bucket below one message with zero threshold kicks at once
        write_reg(REG_LIMIT_PER_WINDOW, 16'd1);
        write_reg(REG_KICK_THRESHOLD, 16'd0);
        send_request(32'h8000_0000);
        send_request(32'h8000_0000);
        wait_for_verdicts();

        write_reg(REG_KICK_THRESHOLD, 16'hFFFF);
        write_reg(REG_LIMIT_PER_WINDOW, 16'hFFFF);
        send_request(32'h8000_0010);
        wait_for_verdicts();

        // allowance above a lowered limit gets cut, then refill truncation
        write_reg(REG_LIMIT_PER_WINDOW, 16'd2049);
        repeat (8) send_request(32'h8000_0010);
        send_request(32'h8000_0011);
        send_request(32'h8000_0014);
        wait_for_verdicts();

        // flood run crosses the kick threshold, a raised threshold turns it back
        write_reg(REG_LIMIT_PER_WINDOW, 16'd1);
        write_reg(REG_KICK_THRESHOLD, 16'd30);
        repeat (BURST_ITEMS) send_request(32'h8000_0014);
        wait_for_verdicts();
        write_reg(REG_KICK_THRESHOLD, 16'd45);
        send_request(32'h8000_0014);
        wait_for_verdicts();

        stamp = 32'h8000_0014;
        for (int chunk = 0; chunk < CHUNKS; chunk++) begin
            case (chunk / 4)
                0: begin
                    sender_idle_pct   = 33;
                    receiver_idle_pct = 88;
                end
                1: begin
                    sender_idle_pct   = 88;
                    receiver_idle_pct = 33;
                end
                default: begin
                    sender_idle_pct   = 0;
                    receiver_idle_pct = 0;
                end
            endcase
            wait_for_verdicts();
            case ($urandom_range(7))
                0: new_limit = 16'd0;
                1: new_limit = 16'd1;
                2: new_limit = 16'd255;
                3: new_limit = 16'd256;
                4: new_limit = 16'd257;
                5: new_limit = LIMIT_RESET;
                6: new_limit = 16'hFFFF;
                default: new_limit = Q_W'($urandom_range(16'hFFFF));
            endcase
            case ($urandom_range(5))
                0: new_threshold = 16'd0;
                1: new_threshold = 16'd1;
                2: new_threshold = 16'd3;
                3: new_threshold = KICK_RESET;
                4: new_threshold = 16'hFFFF;
                default: new_threshold = Q_W'($urandom_range(10));
            endcase
            write_reg(REG_LIMIT_PER_WINDOW, new_limit);
            write_reg(REG_KICK_THRESHOLD, new_threshold);
            // sink stalls long while requests keep coming, so the core backs up
            if (chunk == 9) begin
                long_hold_req = 1'b1;
            end
            for (int n = 0; n < CHUNK_ITEMS; n++) begin
                if (chunk == 5 && n == CHUNK_ITEMS / 2) begin
                    pause_requests(1);
                    wait_for_verdicts();
                end
                // mostly bursts within one second, sometimes gaps, jumps or steps back
                roll = $urandom_range(99);
                if (roll < 55) begin
                    stamp = stamp;
                end else if (roll < 78) begin
                    stamp = stamp + 32'd1;
                end else if (roll < 90) begin
                    stamp = stamp + $urandom_range(9, 2);
                end else if (roll < 95) begin
                    stamp = $urandom;
                end else begin
                    stamp = stamp - $urandom_range(5, 1);
                end
                send_request(stamp);
            end
            pause_requests(1);
        end

        wait_for_verdicts();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
